>>> design/slex_pkg.sv
package slex_pkg;

  // offsets and identifier buffer
  localparam int unsigned OFS_W     = 32;
  localparam int unsigned WORD_MAX  = 12;
  localparam int unsigned WLEN_W    = 4;
  localparam int unsigned WORD_W    = WORD_MAX * 8;
  localparam int unsigned PRIM_CNT  = 7;
  localparam int unsigned KW_CNT    = 21;
  localparam int unsigned WORD_CNT  = PRIM_CNT + KW_CNT;

  // token kinds
  localparam logic [5:0] K_SPACE   = 6'd0;
  localparam logic [5:0] K_STRING  = 6'd1;
  localparam logic [5:0] K_COMMENT = 6'd2;
  localparam logic [5:0] K_SYMBOL  = 6'd3;
  localparam logic [5:0] K_IDENT   = 6'd4;
  localparam logic [5:0] K_PRIM    = 6'd5;
  localparam logic [5:0] K_NUMBER  = 6'd6;
  localparam logic [5:0] K_AND     = 6'd7;
  localparam logic [5:0] K_OR      = 6'd8;
  localparam logic [5:0] K_GTE     = 6'd9;
  localparam logic [5:0] K_LTE     = 6'd10;
  localparam logic [5:0] K_EQ      = 6'd11;
  localparam logic [5:0] K_NEQ     = 6'd12;
  localparam logic [5:0] K_KW_BASE = 6'd13;
  localparam logic [5:0] K_ERROR   = 6'd34;

  // primitive names first, then keywords, in kind order
  localparam logic [WORD_W-1:0] WORD_TXT [WORD_CNT] = '{
    WORD_W'("float"), WORD_W'("int"), WORD_W'("bool"), WORD_W'("byte"),
    WORD_W'("name"), WORD_W'("string"), WORD_W'("text"),
    WORD_W'("true"), WORD_W'("false"), WORD_W'("None"), WORD_W'("dispatcher"),
    WORD_W'("event"), WORD_W'("defaults"), WORD_W'("construction"),
    WORD_W'("function"), WORD_W'("macro"), WORD_W'("collapsed"), WORD_W'("ref"),
    WORD_W'("if"), WORD_W'("else"), WORD_W'("var"), WORD_W'("for"),
    WORD_W'("foreach"), WORD_W'("while"), WORD_W'("break"), WORD_W'("return"),
    WORD_W'("end"), WORD_W'("local")
  };

  localparam logic [WLEN_W-1:0] WORD_LEN [WORD_CNT] = '{
    4'd5, 4'd3, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4,
    4'd4, 4'd5, 4'd4, 4'd10, 4'd5, 4'd8, 4'd12, 4'd8, 4'd5, 4'd9, 4'd3,
    4'd2, 4'd4, 4'd3, 4'd3, 4'd7, 4'd5, 4'd5, 4'd6, 4'd3, 4'd5
  };

  typedef struct packed {
    logic [5:0]       kind;
    logic [2:0]       prim;
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] end_ofs;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [5:0] kind;
    logic [2:0] prim;
  } word_hit_t;

  // parallel compare of the identifier buffer against every reserved word;
  // buffer byte i sits at bits [8*i +: 8], literal chars are right-aligned
  function automatic word_hit_t word_lookup(input logic [WORD_W-1:0] w,
                                            input logic [WLEN_W-1:0] len);
    word_hit_t r;
    logic      hit;
    int        pos;
    r.kind = K_IDENT;
    r.prim = '0;
    for (int j = WORD_CNT - 1; j >= 0; j--) begin
      hit = (len == WORD_LEN[j]);
      for (int i = 0; i < WORD_MAX; i++) begin
        if (i < int'(WORD_LEN[j])) begin
          pos = int'(WORD_LEN[j]) - 1 - i;
          if (w[i*8 +: 8] != WORD_TXT[j][pos*8 +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        if (j < PRIM_CNT) begin
          r.kind = K_PRIM;
          r.prim = 3'(j);
        end else begin
          r.kind = 6'(int'(K_KW_BASE) + j - PRIM_CNT);
          r.prim = '0;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> design/slex_res_fifo.sv
module slex_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    wr_cnt_i,
  input  slex_pkg::res_t wr_a_i,
  input  slex_pkg::res_t wr_b_i,
  output logic          room_o,
  output logic          rd_valid_o,
  input  logic          rd_stall_i,
  output slex_pkg::res_t rd_data_o
);
  import slex_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  // space for a full pair of results
  assign room_o     = (cnt_q <= CNT_W'(DEPTH - 2));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign pop        = rd_valid_o && !rd_stall_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(wr_cnt_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + CNT_W'(wr_cnt_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_a_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= wr_b_i;
    end
  end

endmodule

>>> design/script_lexer.sv
// script_lexer: streaming tokenizer, one source byte per transfer.
// Results of a byte are registered in the result queue on its transfer.
// Throughput: 1 byte per cycle; a byte that closes one token and opens another
// yields two results, drained through a 4-entry result queue one per cycle
// when out_stall_i is low; input stalls when fewer than two entries are free.
// Reset (rst_ni low, asynchronous): idle mode, offsets zero, result queue empty.
module script_lexer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                text_byte_i,
  input  logic                      final_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [5:0]                token_kind_o,
  output logic [2:0]                primitive_index_o,
  output logic [slex_pkg::OFS_W-1:0] start_offset_o,
  output logic [slex_pkg::OFS_W-1:0] end_offset_o,
  output logic                      last_of_run_o
);
  import slex_pkg::*;

  typedef enum logic [12:0] {
    M_IDLE       = 13'b0000000000001,
    M_SPACE      = 13'b0000000000010,
    M_STRING     = 13'b0000000000100,
    M_STR_ESC    = 13'b0000000001000,
    M_SLASH      = 13'b0000000010000,
    M_LINE       = 13'b0000000100000,
    M_BLOCK      = 13'b0000001000000,
    M_BLOCK_STAR = 13'b0000010000000,
    M_IDENT      = 13'b0000100000000,
    M_NUM_INT    = 13'b0001000000000,
    M_NUM_FRAC   = 13'b0010000000000,
    M_DOT        = 13'b0100000000000,
    M_SYM        = 13'b1000000000000
  } mode_e;

  typedef struct packed {
    logic             vld;
    logic             word;
    logic [5:0]       kind;
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] end_ofs;
  } emit_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c == ",") || (c == "{") || (c == "}") || (c == "[") || (c == "]") ||
           (c == "<") || (c == ">") || (c == "+") || (c == "-") || (c == "*") ||
           (c == "&") || (c == "|") || (c == "$") || (c == "#") || (c == ";") ||
           (c == ":") || (c == "=") || (c == "!") || (c == "%") || (c == "^");
  endfunction

  // lexer state
  mode_e             mode_q, mode_n;
  logic [OFS_W-1:0]  start_q, start_n;
  logic [OFS_W-1:0]  pos_q;
  logic [WLEN_W-1:0] len_q, len_n;
  logic [7:0]        held_q, held_n;
  logic [7:0]        word_q [WORD_MAX];

  logic              accept;
  logic              room;
  logic [7:0]        b;
  logic              fin;
  logic [OFS_W-1:0]  p1;
  logic              restart;
  logic              wr_en;
  logic [WLEN_W-1:0] wr_idx;
  logic [WORD_W-1:0] word_mid;
  word_hit_t         hit;
  emit_t             em_c, em_s, em_f;
  emit_t             em_list [3];
  res_t              res_a, res_b;
  logic [1:0]        res_n;
  logic [1:0]        push_cnt;
  res_t              out_res;

  assign b          = text_byte_i;
  assign fin        = final_byte_i;
  assign p1         = pos_q + OFS_W'(1);
  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  // feed the byte to the open token, then open a new one if needed
  always_comb begin
    mode_n  = mode_q;
    start_n = start_q;
    held_n  = held_q;
    len_n   = len_q;
    wr_en   = 1'b0;
    wr_idx  = len_q;
    restart = 1'b0;
    em_c    = '0;
    em_s    = '0;
    unique case (mode_q)
      M_SPACE: begin
        if (!is_space(b)) begin
          em_c    = '{1'b1, 1'b0, K_SPACE, start_q, pos_q};
          restart = 1'b1;
        end
      end
      M_STRING: begin
        if (b == CH_BSL) begin
          mode_n = M_STR_ESC;
        end else if (b == CH_QUOTE) begin
          em_c   = '{1'b1, 1'b0, K_STRING, start_q, p1};
          mode_n = M_IDLE;
        end
      end
      M_STR_ESC: mode_n = M_STRING;
      M_SLASH: begin
        if (b == "/") begin
          mode_n = M_LINE;
        end else if (b == "*") begin
          mode_n = M_BLOCK;
        end else begin
          em_c    = '{1'b1, 1'b0, K_SYMBOL, start_q, pos_q};
          restart = 1'b1;
        end
      end
      M_LINE: begin
        if (b == CH_LF) begin
          em_c    = '{1'b1, 1'b0, K_COMMENT, start_q, pos_q};
          restart = 1'b1;
        end
      end
      M_BLOCK: begin
        if (b == "*") begin
          mode_n = M_BLOCK_STAR;
        end
      end
      M_BLOCK_STAR: begin
        if (b == "/") begin
          em_c   = '{1'b1, 1'b0, K_COMMENT, start_q, p1};
          mode_n = M_IDLE;
        end else if (b != "*") begin
          mode_n = M_BLOCK;
        end
      end
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == "_") begin
          if (len_q < WLEN_W'(WORD_MAX)) begin
            wr_en = 1'b1;
          end
          if (len_q <= WLEN_W'(WORD_MAX)) begin
            len_n = len_q + WLEN_W'(1);
          end
        end else begin
          em_c    = '{1'b1, 1'b1, K_IDENT, start_q, pos_q};
          restart = 1'b1;
        end
      end
      M_NUM_INT: begin
        if (b == ".") begin
          mode_n = M_NUM_FRAC;
        end else if (!is_digit(b)) begin
          em_c    = '{1'b1, 1'b0, K_NUMBER, start_q, pos_q};
          restart = 1'b1;
        end
      end
      M_NUM_FRAC: begin
        if (!is_digit(b)) begin
          em_c    = '{1'b1, 1'b0, K_NUMBER, start_q, pos_q};
          restart = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(b)) begin
          mode_n = M_NUM_FRAC;
        end else begin
          em_c    = '{1'b1, 1'b0, K_SYMBOL, start_q, start_q + OFS_W'(1)};
          restart = 1'b1;
        end
      end
      M_SYM: begin
        if      (held_q == "&" && b == "&") em_c = '{1'b1, 1'b0, K_AND, start_q, p1};
        else if (held_q == "|" && b == "|") em_c = '{1'b1, 1'b0, K_OR,  start_q, p1};
        else if (held_q == ">" && b == "=") em_c = '{1'b1, 1'b0, K_GTE, start_q, p1};
        else if (held_q == "<" && b == "=") em_c = '{1'b1, 1'b0, K_LTE, start_q, p1};
        else if (held_q == "=" && b == "=") em_c = '{1'b1, 1'b0, K_EQ,  start_q, p1};
        else if (held_q == "!" && b == "=") em_c = '{1'b1, 1'b0, K_NEQ, start_q, p1};
        if (em_c.vld) begin
          mode_n = M_IDLE;
        end else begin
          em_c    = '{1'b1, 1'b0, K_SYMBOL, start_q, pos_q};
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase

    // open a new token at this byte
    if (restart) begin
      start_n = pos_q;
      mode_n  = M_IDLE;
      if (is_space(b)) begin
        mode_n = M_SPACE;
      end else if (b == CH_QUOTE) begin
        mode_n = M_STRING;
      end else if (b == "/") begin
        mode_n = M_SLASH;
      end else if (is_alpha(b) || b == "_") begin
        mode_n = M_IDENT;
        wr_en  = 1'b1;
        wr_idx = '0;
        len_n  = WLEN_W'(1);
      end else if (is_digit(b)) begin
        mode_n = M_NUM_INT;
      end else if (b == ".") begin
        mode_n = M_DOT;
      end else if (b == "&" || b == "|" || b == ">" || b == "<" || b == "=" ||
                   b == "!") begin
        mode_n = M_SYM;
        held_n = b;
      end else if (is_sym(b)) begin
        em_s = '{1'b1, 1'b0, K_SYMBOL, pos_q, p1};
      end else begin
        em_s = '{1'b1, 1'b0, K_ERROR, pos_q, p1};
      end
    end
  end

  // identifier buffer as it stands after this byte
  always_comb begin
    for (int i = 0; i < WORD_MAX; i++) begin
      word_mid[i*8 +: 8] = word_q[i];
    end
    if (wr_en) begin
      word_mid[wr_idx*8 +: 8] = b;
    end
  end

  assign hit = word_lookup(word_mid, len_n);

  // end of text: close whatever token is still open
  always_comb begin
    em_f = '0;
    if (fin) begin
      case (mode_n) inside
        M_SPACE:               em_f = '{1'b1, 1'b0, K_SPACE,   start_n, p1};
        M_LINE:                em_f = '{1'b1, 1'b0, K_COMMENT, start_n, p1};
        M_IDENT:               em_f = '{1'b1, 1'b1, K_IDENT,   start_n, p1};
        M_NUM_INT, M_NUM_FRAC: em_f = '{1'b1, 1'b0, K_NUMBER,  start_n, p1};
        M_DOT, M_SYM:          em_f = '{1'b1, 1'b0, K_SYMBOL,  start_n, p1};
        M_STRING, M_STR_ESC, M_SLASH, M_BLOCK, M_BLOCK_STAR:
                               em_f = '{1'b1, 1'b0, K_ERROR,   start_n, p1};
        default:               em_f = '0;
      endcase
    end
  end

  // pack up to two results in order, mark the last one
  always_comb begin
    em_list[0] = em_c;
    em_list[1] = em_s;
    em_list[2] = em_f;
    res_a = '0;
    res_b = '0;
    res_n = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (em_list[i].vld) begin
        if (res_n == 2'd0) begin
          res_a.kind      = em_list[i].word ? hit.kind : em_list[i].kind;
          res_a.prim      = em_list[i].word ? hit.prim : 3'd0;
          res_a.start_ofs = em_list[i].start_ofs;
          res_a.end_ofs   = em_list[i].end_ofs;
          res_n           = 2'd1;
        end else if (res_n == 2'd1) begin
          res_b.kind      = em_list[i].word ? hit.kind : em_list[i].kind;
          res_b.prim      = em_list[i].word ? hit.prim : 3'd0;
          res_b.start_ofs = em_list[i].start_ofs;
          res_b.end_ofs   = em_list[i].end_ofs;
          res_n           = 2'd2;
        end
      end
    end
    res_a.last = (res_n == 2'd1);
    res_b.last = 1'b1;
  end

  assign push_cnt = accept ? res_n : 2'd0;

  // state update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      held_q  <= '0;
    end else if (accept) begin
      mode_q  <= fin ? M_IDLE : mode_n;
      start_q <= start_n;
      pos_q   <= fin ? '0 : p1;
      len_q   <= fin ? '0 : len_n;
      held_q  <= held_n;
    end
  end

  // identifier bytes
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      word_q[wr_idx] <= b;
    end
  end

  slex_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (push_cnt),
    .wr_a_i     (res_a),
    .wr_b_i     (res_b),
    .room_o     (room),
    .rd_valid_o (out_valid_o),
    .rd_stall_i (out_stall_i),
    .rd_data_o  (out_res)
  );

  assign token_kind_o      = out_res.kind;
  assign primitive_index_o = out_res.prim;
  assign start_offset_o    = out_res.start_ofs;
  assign end_offset_o      = out_res.end_ofs;
  assign last_of_run_o     = out_res.last;

endmodule

>>> design/slex_checker.sv
module slex_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [5:0]                 token_kind_o,
  input logic [2:0]                 primitive_index_o,
  input logic [slex_pkg::OFS_W-1:0] start_offset_o,
  input logic [slex_pkg::OFS_W-1:0] end_offset_o,
  input logic                       last_of_run_o
);
  import slex_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(token_kind_o) && $stable(start_offset_o) &&
      $stable(end_offset_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // the second result of a byte is queued together with the first
  a_run_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("run cut short");

  // a result only appears after an input transfer
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without input transfer");

  // primitive index is only set on primitive type names
  a_prim_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (primitive_index_o != 3'd0) |-> (token_kind_o == K_PRIM))
    else $error("primitive index on other kind");

endmodule

bind script_lexer slex_checker u_slex_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .token_kind_o      (token_kind_o),
  .primitive_index_o (primitive_index_o),
  .start_offset_o    (start_offset_o),
  .end_offset_o      (end_offset_o),
  .last_of_run_o     (last_of_run_o)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slex_pkg::*;

  // one source byte as offered on the input channel
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } src_byte_t;

  // one token as expected on the output channel
  typedef struct {
    logic [5:0]  kind;
    logic [2:0]  prim;
    logic [31:0] s_ofs;
    logic [31:0] e_ofs;
    logic        last_run;
  } token_t;

  typedef enum logic [3:0] {
    LX_IDLE, LX_SPACE, LX_STR, LX_STR_ESC, LX_SLASH, LX_LINE, LX_BLOCK,
    LX_BLOCK_STAR, LX_WORD, LX_INT, LX_FRAC, LX_DOT, LX_SYM
  } lex_mode_e;

  localparam int NUM_PRIM  = 7;
  localparam int NUM_WORDS = 28;
  localparam int PHASE_LEN = 300;

  // primitive type names first, then keywords in kind order
  string rsv_words [NUM_WORDS] = '{
    "float", "int", "bool", "byte", "name", "string", "text",
    "true", "false", "None", "dispatcher", "event", "defaults", "construction",
    "function", "macro", "collapsed", "ref", "if", "else", "var", "for",
    "foreach", "while", "break", "return", "end", "local"
  };
  string sym_chars = ",{}[]<>+-*&|$#;:=!%^";
  string op_pairs  = "&&||>=<===!=";

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  text_byte_i  = '0;
  logic        final_byte_i = 1'b0;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [5:0]  token_kind_o;
  logic [2:0]  primitive_index_o;
  logic [31:0] start_offset_o;
  logic [31:0] end_offset_o;
  logic        last_of_run_o;

  src_byte_t  src_q [$];
  token_t     token_q [$];
  token_t     step_tokens [$];
  logic [7:0] text_buf [$];
  src_byte_t  drv_byte;
  token_t     want_tok;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int queued      = 0;
  int bytes_sent  = 0;
  int texts_sent  = 0;
  int tokens_seen = 0;
  int errors      = 0;
  int hold_left   = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  // lexer state mirrored by the predictor
  lex_mode_e   lx_mode  = LX_IDLE;
  logic [31:0] lx_start = '0;
  logic [31:0] lx_pos   = '0;
  logic [7:0]  lx_word [WORD_MAX];
  int          lx_wlen  = 0;
  logic [7:0]  lx_held  = '0;

  script_lexer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .text_byte_i       (text_byte_i),
    .final_byte_i      (final_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .token_kind_o      (token_kind_o),
    .primitive_index_o (primitive_index_o),
    .start_offset_o    (start_offset_o),
    .end_offset_o      (end_offset_o),
    .last_of_run_o     (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // character classes
  function automatic bit is_space(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_word_chr(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic bit in_sym(input logic [7:0] b);
    for (int i = 0; i < sym_chars.len(); i++) begin
      if (sym_chars[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  // two-byte operator kind, symbol when the pair is no operator
  function automatic logic [5:0] op_kind(input logic [7:0] a, input logic [7:0] b);
    if (a == "&" && b == "&") return K_AND;
    if (a == "|" && b == "|") return K_OR;
    if (a == ">" && b == "=") return K_GTE;
    if (a == "<" && b == "=") return K_LTE;
    if (a == "=" && b == "=") return K_EQ;
    if (a == "!" && b == "=") return K_NEQ;
    return K_SYMBOL;
  endfunction

  function automatic void add_token(input logic [5:0] k, input logic [2:0] pr,
                                    input logic [31:0] s, input logic [31:0] e);
    token_t t;
    t.kind     = k;
    t.prim     = pr;
    t.s_ofs    = s;
    t.e_ofs    = e;
    t.last_run = 1'b0;
    if (step_tokens.size() < 2) step_tokens.push_back(t);
  endfunction

  // identifier, keyword or primitive name from the held word bytes
  function automatic void word_token(input logic [31:0] e);
    bit same;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (lx_wlen == rsv_words[i].len()) begin
        same = 1'b1;
        for (int j = 0; j < lx_wlen; j++) begin
          if (lx_word[j] != rsv_words[i][j]) same = 1'b0;
        end
        if (same) begin
          if (i < NUM_PRIM) add_token(K_PRIM, 3'(i), lx_start, e);
          else add_token(K_KW_BASE + 6'(i - NUM_PRIM), '0, lx_start, e);
          return;
        end
      end
    end
    add_token(K_IDENT, '0, lx_start, e);
  endfunction

  // feed a byte to the open token, 1 when the byte opens a new token
  function automatic bit lex_continue(input logic [7:0] b, input logic [31:0] p);
    logic [5:0] k;
    case (lx_mode)
      LX_SPACE: begin
        if (is_space(b)) return 1'b0;
        add_token(K_SPACE, '0, lx_start, p);
        return 1'b1;
      end
      LX_STR: begin
        if (b == "\\") lx_mode = LX_STR_ESC;
        else if (b == "\"") begin
          add_token(K_STRING, '0, lx_start, p + 32'd1);
          lx_mode = LX_IDLE;
        end
        return 1'b0;
      end
      LX_STR_ESC: begin
        lx_mode = LX_STR;
        return 1'b0;
      end
      LX_SLASH: begin
        if (b == "/") begin
          lx_mode = LX_LINE;
          return 1'b0;
        end
        if (b == "*") begin
          lx_mode = LX_BLOCK;
          return 1'b0;
        end
        add_token(K_SYMBOL, '0, lx_start, p);
        return 1'b1;
      end
      LX_LINE: begin
        if (b != "\n") return 1'b0;
        add_token(K_COMMENT, '0, lx_start, p);
        return 1'b1;
      end
      LX_BLOCK: begin
        if (b == "*") lx_mode = LX_BLOCK_STAR;
        return 1'b0;
      end
      LX_BLOCK_STAR: begin
        if (b == "/") begin
          add_token(K_COMMENT, '0, lx_start, p + 32'd1);
          lx_mode = LX_IDLE;
        end else if (b != "*") begin
          lx_mode = LX_BLOCK;
        end
        return 1'b0;
      end
      LX_WORD: begin
        if (is_word_chr(b)) begin
          if (lx_wlen < WORD_MAX) lx_word[lx_wlen] = b;
          if (lx_wlen <= WORD_MAX) lx_wlen++;
          return 1'b0;
        end
        word_token(p);
        return 1'b1;
      end
      LX_INT: begin
        if (is_digit(b)) return 1'b0;
        if (b == ".") begin
          lx_mode = LX_FRAC;
          return 1'b0;
        end
        add_token(K_NUMBER, '0, lx_start, p);
        return 1'b1;
      end
      LX_FRAC: begin
        if (is_digit(b)) return 1'b0;
        add_token(K_NUMBER, '0, lx_start, p);
        return 1'b1;
      end
      LX_DOT: begin
        if (is_digit(b)) begin
          lx_mode = LX_FRAC;
          return 1'b0;
        end
        add_token(K_SYMBOL, '0, lx_start, lx_start + 32'd1);
        return 1'b1;
      end
      LX_SYM: begin
        k = op_kind(lx_held, b);
        if (k != K_SYMBOL) begin
          add_token(k, '0, lx_start, p + 32'd1);
          lx_mode = LX_IDLE;
          return 1'b0;
        end
        add_token(K_SYMBOL, '0, lx_start, p);
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  // open a token on byte b at offset p
  function automatic void lex_open(input logic [7:0] b, input logic [31:0] p);
    lx_start = p;
    lx_mode  = LX_IDLE;
    if (is_space(b)) lx_mode = LX_SPACE;
    else if (b == "\"") lx_mode = LX_STR;
    else if (b == "/") lx_mode = LX_SLASH;
    else if (is_alpha(b) || b == "_") begin
      lx_mode    = LX_WORD;
      lx_word[0] = b;
      lx_wlen    = 1;
    end
    else if (is_digit(b)) lx_mode = LX_INT;
    else if (b == ".") lx_mode = LX_DOT;
    else if (b == "&" || b == "|" || b == ">" || b == "<" || b == "=" || b == "!") begin
      lx_mode = LX_SYM;
      lx_held = b;
    end
    else if (b != 8'd0 && in_sym(b)) add_token(K_SYMBOL, '0, p, p + 32'd1);
    else add_token(K_ERROR, '0, p, p + 32'd1);
  endfunction

  // end of text: close the pending token
  function automatic void lex_flush(input logic [31:0] e);
    case (lx_mode) inside
      LX_SPACE:                 add_token(K_SPACE, '0, lx_start, e);
      LX_LINE:                  add_token(K_COMMENT, '0, lx_start, e);
      LX_WORD:                  word_token(e);
      LX_INT, LX_FRAC:          add_token(K_NUMBER, '0, lx_start, e);
      LX_DOT, LX_SYM:           add_token(K_SYMBOL, '0, lx_start, e);
      LX_STR, LX_STR_ESC, LX_SLASH, LX_BLOCK, LX_BLOCK_STAR:
                                add_token(K_ERROR, '0, lx_start, e);
      default: ;
    endcase
  endfunction

  // expected tokens for one accepted byte
  function automatic void lex_predict(input logic [7:0] b, input logic fin);
    logic [31:0] p;
    p = lx_pos;
    step_tokens.delete();
    if (lex_continue(b, p)) lex_open(b, p);
    if (fin) begin
      lex_flush(p + 32'd1);
      lx_mode = LX_IDLE;
      lx_pos  = '0;
      lx_wlen = 0;
    end else begin
      lx_pos = p + 32'd1;
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last_run = 1'b1;
    foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // stimulus construction
  task automatic push_byte(input logic [7:0] b, input bit fin);
    src_byte_t s;
    s.text_byte  = b;
    s.final_byte = fin;
    src_q.push_back(s);
    queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_chr(input bit lead);
    int r;
    r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62 && !lead) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] digit_chr();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // one well-formed token with random content, or a noise byte
  task automatic gen_token();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 12))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) text_buf.push_back($urandom_range(0, 1) ? 8'(" ") : 8'($urandom_range(9, 13)));
      end
      1: begin
        add_str("\"");
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            add_str("\\");
            text_buf.push_back(8'($urandom_range(0, 255)));
          end else begin
            c = 8'($urandom_range(0, 255));
            if (c == "\"" || c == "\\") c = "s";
            text_buf.push_back(c);
          end
        end
        add_str("\"");
      end
      2: begin
        add_str("//");
        n = $urandom_range(0, 6);
        repeat (n) begin
          c = 8'($urandom_range(0, 255));
          if (c == "\n") c = "c";
          text_buf.push_back(c);
        end
        add_str("\n");
      end
      3: begin
        add_str("/*");
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: add_str("*");
            1: add_str("/");
            default: text_buf.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 3) == 0) add_str("**/");
        else add_str("*/");
      end
      4, 5: begin
        add_str(rsv_words[$urandom_range(0, NUM_WORDS - 1)]);
        if ($urandom_range(0, 4) == 0) text_buf.push_back(word_chr(1'b0));
      end
      6: begin
        n = $urandom_range(0, 15);
        text_buf.push_back(word_chr(1'b1));
        repeat (n) text_buf.push_back(word_chr(1'b0));
      end
      7: begin
        n = $urandom_range(1, 4);
        repeat (n) text_buf.push_back(digit_chr());
        if ($urandom_range(0, 1)) begin
          add_str(".");
          n = $urandom_range(0, 3);
          repeat (n) text_buf.push_back(digit_chr());
        end
      end
      8: begin
        add_str(".");
        n = $urandom_range(0, 3);
        repeat (n) text_buf.push_back(digit_chr());
      end
      9: text_buf.push_back(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
      10: begin
        n = 2 * $urandom_range(0, 5);
        text_buf.push_back(op_pairs[n]);
        text_buf.push_back(op_pairs[n + 1]);
      end
      11: add_str("/");
      default: text_buf.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 9) < 4) add_str(" ");
  endtask

  // one text of random tokens, sometimes cut short inside a token
  task automatic gen_text();
    int target;
    int cut;
    text_buf.delete();
    target = $urandom_range(1, 40);
    while (text_buf.size() < target) gen_token();
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, text_buf.size());
      while (text_buf.size() > cut) void'(text_buf.pop_back());
    end
    foreach (text_buf[i]) push_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // input driver, predicts on every transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      text_byte_i  <= '0;
      final_byte_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lex_predict(text_byte_i, final_byte_i);
        bytes_sent++;
        if (final_byte_i) texts_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (src_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          drv_byte = src_q.pop_front();
          in_valid_i   <= 1'b1;
          text_byte_i  <= drv_byte.text_byte;
          final_byte_i <= drv_byte.final_byte;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token, expected none, got kind %0d at %0d..%0d",
                   $time, token_kind_o, start_offset_o, end_offset_o);
          errors++;
        end else begin
          want_tok = token_q.pop_front();
          check_field("token_kind", 32'(want_tok.kind), 32'(token_kind_o));
          check_field("primitive_index", 32'(want_tok.prim), 32'(primitive_index_o));
          check_field("start_offset", want_tok.s_ofs, start_offset_o);
          check_field("end_offset", want_tok.e_ofs, end_offset_o);
          check_field("last_of_run", 32'(want_tok.last_run), 32'(last_of_run_o));
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // long receiver hold-off so the result queue fills and input stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // stimulus phases and end of run
  initial begin
    // sender idles less than the receiver
    tx_idle_pct = 21;
    rx_idle_pct = 57;
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("(/");
    push_text("12.");
    push_text("/*\"");
    push_text("\"\\");
    push_text("x//\n=");
    push_text(".;!=");
    push_text("int");
    while (queued < PHASE_LEN) gen_text();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (src_q.size() != 0) @(posedge clk_i);

    // receiver idles less than the sender
    tx_idle_pct = 57;
    rx_idle_pct = 21;
    while (queued < 2 * PHASE_LEN) gen_text();
    while (src_q.size() != 0) @(posedge clk_i);

    // no idling, with one long receiver hold-off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    while (queued < 3 * PHASE_LEN) gen_text();

    while (src_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("lexed %0d bytes in %0d texts, checked %0d tokens, %0d mismatches",
             bytes_sent, texts_sent, tokens_seen, errors);
    $display("texts mixed keywords, strings, comments, numbers, operators and noise bytes");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("timeout with %0d tokens still expected", token_q.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
